// File: hdl/wnm_pkg.sv
// Shared constants, types and helper functions for the wildcard name matcher.
// Depends on nothing; imported by wildcard_name_nfa_matcher and its bench.
`default_nettype none
package wnm_pkg;

   localparam int MAX_STATES  = 32;
   localparam int POS_W       = MAX_STATES + 1;
   localparam int IDX_W       = $clog2(MAX_STATES);
   localparam int LEN_W       = $clog2(MAX_STATES + 1);
   localparam int CLOSE_STEPS = $clog2(POS_W);

   typedef logic [POS_W-1:0]      pos_vec_type;
   typedef logic [MAX_STATES-1:0] elem_vec_type;

   // request kinds carried in tuser
   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_BYTE  = 2'd1;
   localparam logic [1:0] CMD_END   = 2'd2;

   // pattern element kinds
   localparam logic [1:0] TYPE_LITERAL = 2'd0;
   localparam logic [1:0] TYPE_PERCENT = 2'd1;
   localparam logic [1:0] TYPE_STAR    = 2'd2;

   // leading INBOX decision
   localparam logic [1:0] PFX_UNDECIDED = 2'd0;
   localparam logic [1:0] PFX_EXACT     = 2'd1;
   localparam logic [1:0] PFX_FOLDED    = 2'd2;

   // control register indexes
   localparam logic [1:0] CSR_SEPARATOR = 2'd0;
   localparam logic [1:0] CSR_FOLD_EN   = 2'd1;
   localparam logic [1:0] CSR_LENGTH    = 2'd2;

   localparam logic [2:0] INBOX_LEN = 3'd5;
   localparam logic [7:0] SEP_RESET = 8'd47;

   function automatic logic [7:0] up_case(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= 8'h61 && c <= 8'h7a) begin
         r = c - 8'd32;
      end
      return r;
   endfunction

   function automatic logic [7:0] inbox_char(input logic [2:0] pos);
      logic [7:0] r;
      case (pos)
         3'd0: r = 8'h49;
         3'd1: r = 8'h4e;
         3'd2: r = 8'h42;
         3'd3: r = 8'h4f;
         3'd4: r = 8'h58;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   // Epsilon closure: an active wildcard also activates the next position.
   // Prefix form of c[i] = v[i] | (c[i-1] & wild[i-1]).
   function automatic pos_vec_type close_fwd(input pos_vec_type v, input elem_vec_type wild);
      pos_vec_type g;
      pos_vec_type p;
      g = v;
      p = {wild, 1'b0};
      for (int k = 0; k < CLOSE_STEPS; k++) begin
         g = g | (p & (g << (1 << k)));
         p = p & (p << (1 << k));
      end
      return g;
   endfunction

   // Suffix form of s[k] = e[k] | (q[k] & s[k+1]).
   function automatic elem_vec_type close_bwd(input elem_vec_type e, input elem_vec_type q);
      elem_vec_type g;
      elem_vec_type p;
      g = e;
      p = q;
      for (int k = 0; k < CLOSE_STEPS; k++) begin
         g = g | (p & (g >> (1 << k)));
         p = p & (p >> (1 << k));
      end
      return g;
   endfunction

endpackage
`default_nettype wire

// File: hdl/wildcard_name_nfa_matcher.sv
// Wildcard mailbox-name matcher: pattern table, two NFA vectors, result register.
// Depends on wnm_pkg (constants, types, closure functions).
//
// Usage:
//   Control registers (separator, INBOX folding enable, pattern length) are
//   written through csr_we/csr_index/csr_wdata while the block is idle; each
//   write restarts the name in progress.
//   Requests arrive on req_*: tuser gives the kind (write pattern entry, name
//   byte, end of name). Pattern writes and name bytes give no response; an
//   end-of-name request gives exactly one response on rsp_* with the
//   matched, children and parent flags.
//   A request is taken into an input register and evaluated from there in
//   one pass over all 33 NFA positions; an end result lands in the response
//   register, which drives rsp_tvalid.
//   One request per cycle is sustained unless an end of name is held (below);
//   the limit is the single NFA update per byte, built on the prior byte's vector.
//   When rsp_tready is low with a response pending, name bytes and pattern
//   writes still flow; only an end-of-name request waits in the input
//   register, and req_tready drops until the response is taken.
//   Reset: separator 47, folding off, length 0, no request or response held,
//   name trackers at their start values. Pattern entries are undefined until
//   written.
`default_nettype none
module wildcard_name_nfa_matcher
   import wnm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // entry_index[4:0], entry_type[6:5], entry_char[14:7], name_byte[22:15], zero [23]
   input  wire logic [23:0] req_tdata,
   // cmd[1:0]
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // matched[0], children[1], parent[2], zero [7:3]
   output logic [7:0]       rsp_tdata,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_wdata
);

   // control registers
   logic [7:0]       sep_ff;
   logic             fold_en_ff;
   logic [LEN_W-1:0] plen_ff;

   // pattern table, one entry per NFA position but the accepting one
   logic [1:0] pat_type_ff [MAX_STATES];
   logic [7:0] pat_char_ff [MAX_STATES];

   // input register
   logic             in_valid_ff, in_valid_in;
   logic [1:0]       in_cmd_ff;
   logic [IDX_W-1:0] in_idx_ff;
   logic [1:0]       in_type_ff;
   logic [7:0]       in_char_ff;
   logic [7:0]       in_byte_ff;

   // name trackers; vectors are held before closure
   pos_vec_type exact_ff, exact_in;
   pos_vec_type folded_ff, folded_in;
   logic [2:0]  progress_ff, progress_in;
   logic [1:0]  pfx_ff, pfx_in;
   logic [1:0]  parent_ff, parent_in;
   logic        last_sep_ff, last_sep_in;

   // response register
   logic       rsp_valid_ff, rsp_valid_in;
   logic       matched_ff, matched_in;
   logic       children_ff, children_in;
   logic       parent_out_ff, parent_out_in;

   logic             in_go;
   logic             do_write, do_byte, do_end, do_restart;
   logic [LEN_W-1:0] n_len;
   pos_vec_type      below_n, at_n;
   elem_vec_type     lit_m, pct_m, star_m, wild_m;
   elem_vec_type     hit_exact, hit_fold, eats_sep, chain_m, sep_reach;
   pos_vec_type      exact_cur, folded_cur, sel_cur;
   logic             acc_exact, acc_folded;
   logic             is_sep, inbox_hit, commit_fold, use_fold;
   logic             step_exact, step_folded;
   pos_vec_type      exact_step, folded_step;
   elem_vec_type     adv_folded;
   logic             any_act, any_reach;

   // Hold an end-of-name request while the response register is full and not taken.
   assign in_go      = in_valid_ff && (in_cmd_ff != CMD_END || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || in_go;
   assign do_write   = in_go && in_cmd_ff == CMD_WRITE;
   assign do_byte    = in_go && in_cmd_ff == CMD_BYTE;
   assign do_end     = in_go && in_cmd_ff == CMD_END;
   assign do_restart = do_write || do_end ||
                       (csr_we && (csr_index == CSR_SEPARATOR || csr_index == CSR_FOLD_EN ||
                                   csr_index == CSR_LENGTH));

   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;

   // Saturate the pattern length at the table depth.
   assign n_len = (plen_ff > LEN_W'(MAX_STATES)) ? LEN_W'(MAX_STATES) : plen_ff;

   assign is_sep = in_byte_ff == sep_ff;

   // Per-position decode of the pattern; everything past the length is masked.
   always_comb begin
      for (int i = 0; i < POS_W; i++) begin
         below_n[i] = LEN_W'(i) < n_len;
         at_n[i]    = LEN_W'(i) == n_len;
      end
      for (int i = 0; i < MAX_STATES; i++) begin
         pct_m[i]     = below_n[i] && pat_type_ff[i] == TYPE_PERCENT;
         star_m[i]    = below_n[i] && pat_type_ff[i] == TYPE_STAR;
         lit_m[i]     = below_n[i] && !pct_m[i] && !star_m[i];
         wild_m[i]    = pct_m[i] || star_m[i];
         hit_exact[i] = pat_char_ff[i] == in_byte_ff;
         hit_fold[i]  = up_case(pat_char_ff[i]) == up_case(in_byte_ff);
         eats_sep[i]  = star_m[i] || (lit_m[i] && pat_char_ff[i] == sep_ff);
         chain_m[i]   = wild_m[i] && below_n[i+1];
      end
   end

   // Close both vectors against the current pattern.
   assign exact_cur  = close_fwd(exact_ff, wild_m);
   assign folded_cur = close_fwd(folded_ff, wild_m);
   assign acc_exact  = |(exact_cur & at_n);
   assign acc_folded = |(folded_cur & at_n);

   // INBOX tracking (folding on): while leading bytes spell INBOX, step both vectors.
   assign inbox_hit = pfx_ff == PFX_UNDECIDED && fold_en_ff && progress_ff < INBOX_LEN &&
                      up_case(in_byte_ff) == inbox_char(progress_ff);
   assign commit_fold = pfx_ff == PFX_FOLDED ||
                        (pfx_ff == PFX_UNDECIDED && fold_en_ff && progress_ff == INBOX_LEN &&
                         is_sep);
   assign step_exact  = inbox_hit || !commit_fold;
   assign step_folded = inbox_hit || commit_fold;

   // Step: stars hold, percents hold on non-separators, matching literals advance.
   assign adv_folded  = inbox_hit ? hit_fold : hit_exact;
   assign exact_step  =
      {1'b0, exact_cur[MAX_STATES-1:0] & (star_m | (pct_m & {MAX_STATES{!is_sep}}))}
      | {exact_cur[MAX_STATES-1:0] & lit_m & hit_exact, 1'b0};
   assign folded_step =
      {1'b0, folded_cur[MAX_STATES-1:0] & (star_m | (pct_m & {MAX_STATES{!is_sep}}))}
      | {folded_cur[MAX_STATES-1:0] & lit_m & adv_folded, 1'b0};

   // End of name: pick the committed vector and look for separator reach.
   assign use_fold  = pfx_ff == PFX_FOLDED ||
                      (pfx_ff == PFX_UNDECIDED && fold_en_ff && progress_ff == INBOX_LEN);
   assign sel_cur   = use_fold ? folded_cur : exact_cur;
   assign sep_reach = close_bwd(eats_sep, chain_m);
   assign any_act   = |(sel_cur[MAX_STATES-1:0] & below_n[MAX_STATES-1:0]);
   assign any_reach = |(sel_cur[MAX_STATES-1:0] & below_n[MAX_STATES-1:0] & sep_reach);

   always_comb begin
      exact_in    = exact_ff;
      folded_in   = folded_ff;
      progress_in = progress_ff;
      pfx_in      = pfx_ff;
      parent_in   = parent_ff;
      last_sep_in = last_sep_ff;
      if (do_restart) begin
         exact_in    = pos_vec_type'(1);
         folded_in   = pos_vec_type'(1);
         progress_in = '0;
         pfx_in      = PFX_UNDECIDED;
         parent_in   = '0;
         last_sep_in = 1'b0;
      end else if (do_byte) begin
         last_sep_in = is_sep;
         if (inbox_hit) begin
            progress_in = progress_ff + 3'd1;
         end else if (pfx_ff == PFX_UNDECIDED) begin
            pfx_in = commit_fold ? PFX_FOLDED : PFX_EXACT;
         end
         if (step_exact) begin
            exact_in     = exact_step;
            parent_in[0] = parent_ff[0] | (is_sep & acc_exact);
         end
         if (step_folded) begin
            folded_in    = folded_step;
            parent_in[1] = parent_ff[1] | (is_sep & acc_folded);
         end
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      matched_in    = matched_ff;
      children_in   = children_ff;
      parent_out_in = parent_out_ff;
      if (do_end) begin
         rsp_valid_in  = 1'b1;
         matched_in    = |(sel_cur & at_n);
         children_in   = !matched_in && any_act && (last_sep_ff || any_reach);
         parent_out_in = !matched_in && (use_fold ? parent_ff[1] : parent_ff[0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sep_ff       <= SEP_RESET;
         fold_en_ff   <= 1'b0;
         plen_ff      <= '0;
         in_valid_ff  <= 1'b0;
         exact_ff     <= pos_vec_type'(1);
         folded_ff    <= pos_vec_type'(1);
         progress_ff  <= '0;
         pfx_ff       <= PFX_UNDECIDED;
         parent_ff    <= '0;
         last_sep_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SEPARATOR: sep_ff     <= csr_wdata;
               CSR_FOLD_EN:   fold_en_ff <= csr_wdata[0];
               CSR_LENGTH:    plen_ff    <= csr_wdata[LEN_W-1:0];
               default: ;
            endcase
         end
         in_valid_ff  <= in_valid_in;
         exact_ff     <= exact_in;
         folded_ff    <= folded_in;
         progress_ff  <= progress_in;
         pfx_ff       <= pfx_in;
         parent_ff    <= parent_in;
         last_sep_ff  <= last_sep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_cmd_ff  <= req_tuser;
         in_idx_ff  <= req_tdata[4:0];
         in_type_ff <= req_tdata[6:5];
         in_char_ff <= req_tdata[14:7];
         in_byte_ff <= req_tdata[22:15];
      end
      if (do_write) begin
         pat_type_ff[in_idx_ff] <= in_type_ff;
         pat_char_ff[in_idx_ff] <= in_char_ff;
      end
      matched_ff    <= matched_in;
      children_ff   <= children_in;
      parent_out_ff <= parent_out_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, parent_out_ff, children_ff, matched_ff};

   // A full match never reports children or parent.
   a_match_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(matched_ff && (children_ff || parent_out_ff)))
      else $error("match reported together with children or parent");

   // INBOX progress never runs past the word.
   a_progress_range: assert property (@(posedge clock) disable iff (reset)
      progress_ff <= INBOX_LEN)
      else $error("INBOX progress out of range");

   // A register write restarts the name trackers.
   a_csr_restart: assert property (@(posedge clock) disable iff (reset)
      (csr_we && (csr_index == CSR_SEPARATOR || csr_index == CSR_FOLD_EN ||
                  csr_index == CSR_LENGTH))
      |=> (progress_ff == 3'd0 && parent_ff == 2'd0 && pfx_ff == PFX_UNDECIDED))
      else $error("trackers not restarted after register write");

   // A held request is never dropped from the input register.
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !in_go) |=> (in_valid_ff && $stable(in_cmd_ff)))
      else $error("stalled request lost from input register");

endmodule
`default_nettype wire

// File: bench/wildcard_name_nfa_matcher_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for wildcard_name_nfa_matcher: streams pattern writes and name bytes,
// keeps its own NFA copy of the matcher and checks every end-of-name verdict.
// Depends on wnm_pkg (command, type and register codes) and the matcher RTL.
module wildcard_name_nfa_matcher_tb;
   import wnm_pkg::*;

   // codes the package leaves unnamed
   localparam logic [1:0] CMD_UNUSED       = 2'd3;
   localparam logic [1:0] TYPE_ALT_LITERAL = 2'd3;

   localparam logic [39:0] INBOX_WORD      = "INBOX";
   localparam int          TARGET_REQUESTS = 1150;
   localparam int          SETTLE_CYCLES   = 6;
   localparam int          STALL_LIMIT     = 2000;
   localparam int          REPORT_LIMIT    = 10;

   typedef struct packed {
      logic [1:0] cmd;
      logic [4:0] entry_index;
      logic [1:0] entry_type;
      logic [7:0] entry_char;
      logic [7:0] name_byte;
   } request_type;

   typedef struct packed {
      logic matched;
      logic children;
      logic parent;
   } verdict_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // entry_index[4:0], entry_type[6:5], entry_char[14:7], name_byte[22:15], zero [23]
   logic [23:0] req_tdata  = '0;
   // cmd[1:0]
   logic [1:0]  req_tuser  = CMD_WRITE;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // matched[0], children[1], parent[2], zero [7:3]
   logic [7:0]  rsp_tdata;
   logic        csr_we     = 1'b0;
   logic [1:0]  csr_index  = CSR_SEPARATOR;
   logic [7:0]  csr_wdata  = '0;

   wildcard_name_nfa_matcher DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // Matcher copy: configuration, pattern table and name trackers as the block
   // should hold them after every accepted request.
   // ---------------------------------------------------------------------------
   logic [7:0]  cfg_sep  = SEP_RESET;
   logic        cfg_fold = 1'b0;
   logic [5:0]  cfg_len  = '0;
   logic [9:0]  pat_tbl [MAX_STATES];     // kind in 9:8, byte in 7:0
   pos_vec_type act_exact;
   pos_vec_type act_folded;
   logic [2:0]  pfx_count;
   logic [1:0]  pfx_mode;
   logic [1:0]  parent_hits;              // bit 0 exact track, bit 1 folded track
   logic        after_sep;

   // pattern as the stimulus side last wrote it, used to build matching names
   logic [1:0]  stim_kind [MAX_STATES];
   logic [7:0]  stim_chr  [MAX_STATES];

   request_type pending_requests [$];
   verdict_type expected_verdicts [$];
   request_type bus_req;
   int          pushed_count   = 0;
   int          accepted_count = 0;
   int          failures       = 0;
   int          quiet_cycles   = 0;
   int          send_gap_pct   = 34;
   int          recv_gap_pct   = 51;

   function automatic int live_len();
      return (cfg_len > MAX_STATES) ? MAX_STATES : int'(cfg_len);
   endfunction

   function automatic logic is_wild(int i);
      return pat_tbl[i][9:8] == TYPE_PERCENT || pat_tbl[i][9:8] == TYPE_STAR;
   endfunction

   function automatic logic [7:0] fold_upper(logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7a) ? c - 8'd32 : c;
   endfunction

   function automatic logic [7:0] inbox_letter(int k);
      return INBOX_WORD[8*(4-k) +: 8];
   endfunction

   // an active wildcard also activates the position after it
   function automatic pos_vec_type eps_close(pos_vec_type v);
      pos_vec_type r;
      r = v;
      for (int i = 0; i < live_len(); i++) begin
         if (r[i] && is_wild(i)) begin
            r[i+1] = 1'b1;
         end
      end
      return r;
   endfunction

   function automatic pos_vec_type advance(pos_vec_type v, logic [7:0] b, logic fold);
      pos_vec_type nxt;
      logic [7:0]  c;
      nxt = '0;
      for (int i = 0; i < live_len(); i++) begin
         if (v[i]) begin
            c = pat_tbl[i][7:0];
            case (pat_tbl[i][9:8])
               TYPE_PERCENT: begin
                  if (b != cfg_sep) nxt[i] = 1'b1;
               end
               TYPE_STAR: begin
                  nxt[i] = 1'b1;
               end
               default: begin
                  if (c == b || (fold && fold_upper(c) == fold_upper(b))) nxt[i+1] = 1'b1;
               end
            endcase
         end
      end
      return eps_close(nxt);
   endfunction

   // drop the name in progress and go back to the closed start position
   function automatic void restart_name();
      act_exact   = eps_close(pos_vec_type'(1));
      act_folded  = act_exact;
      pfx_count   = '0;
      pfx_mode    = PFX_UNDECIDED;
      parent_hits = '0;
      after_sep   = 1'b0;
   endfunction

   // Advance the matcher copy by one accepted request; queue the verdict of an end.
   task automatic update_matcher(request_type r);
      int          n;
      logic [7:0]  b;
      logic        on_prefix;
      pos_vec_type v;
      logic [MAX_STATES:0] sep_reach;
      logic [1:0]  t;
      logic        eats_sep;
      logic        any_live;
      logic        any_reach;
      verdict_type vd;
      n = live_len();
      b = r.name_byte;
      case (r.cmd)
         CMD_WRITE: begin
            pat_tbl[r.entry_index] = {r.entry_type, r.entry_char};
            restart_name();
         end
         CMD_BYTE: begin
            on_prefix = 1'b0;
            if (pfx_mode == PFX_UNDECIDED) begin
               if (!cfg_fold) begin
                  pfx_mode = PFX_EXACT;
               end else if (pfx_count < INBOX_LEN) begin
                  // still inside a possible INBOX: run both tracks side by side
                  if (fold_upper(b) == inbox_letter(pfx_count)) begin
                     on_prefix = 1'b1;
                     parent_hits[0] |= (b == cfg_sep) && act_exact[n];
                     parent_hits[1] |= (b == cfg_sep) && act_folded[n];
                     act_exact  = advance(act_exact, b, 1'b0);
                     act_folded = advance(act_folded, b, 1'b1);
                     pfx_count++;
                  end else begin
                     pfx_mode = PFX_EXACT;
                  end
               end else begin
                  // INBOX seen: folding holds only if a separator follows
                  pfx_mode = (b == cfg_sep) ? PFX_FOLDED : PFX_EXACT;
               end
            end
            if (!on_prefix) begin
               if (pfx_mode == PFX_FOLDED) begin
                  parent_hits[1] |= (b == cfg_sep) && act_folded[n];
                  act_folded = advance(act_folded, b, 1'b0);
               end else begin
                  parent_hits[0] |= (b == cfg_sep) && act_exact[n];
                  act_exact = advance(act_exact, b, 1'b0);
               end
            end
            after_sep = b == cfg_sep;
         end
         CMD_END: begin
            if (pfx_mode == PFX_UNDECIDED) begin
               pfx_mode = (cfg_fold && pfx_count == INBOX_LEN) ? PFX_FOLDED : PFX_EXACT;
            end
            v = (pfx_mode == PFX_FOLDED) ? act_folded : act_exact;
            vd.matched  = 1'b0;
            vd.children = 1'b0;
            vd.parent   = 1'b0;
            if (v[n]) begin
               vd.matched = 1'b1;
            end else begin
               // positions from which some element could still swallow a separator
               sep_reach = '0;
               for (int k = n - 1; k >= 0; k--) begin
                  t = pat_tbl[k][9:8];
                  eats_sep = t == TYPE_STAR ||
                     ((t == TYPE_LITERAL || t == TYPE_ALT_LITERAL) && pat_tbl[k][7:0] == cfg_sep);
                  sep_reach[k] = eats_sep || (is_wild(k) && k + 1 < n && sep_reach[k+1]);
               end
               any_live  = 1'b0;
               any_reach = 1'b0;
               for (int k = 0; k < n; k++) begin
                  if (v[k]) begin
                     any_live = 1'b1;
                     if (sep_reach[k]) any_reach = 1'b1;
                  end
               end
               vd.children = any_live && (after_sep || any_reach);
               vd.parent   = (pfx_mode == PFX_FOLDED) ? parent_hits[1] : parent_hits[0];
            end
            expected_verdicts.push_back(vd);
            restart_name();
         end
         default: begin
            // unknown command: no effect at all
         end
      endcase
   endtask

   task automatic note_failure(string msg);
      failures++;
      if (failures <= REPORT_LIMIT) $display("%s", msg);
   endtask

   // ---------------------------------------------------------------------------
   // Driver: hold each request until taken, feed the matcher copy on acceptance
   // and insert random gaps only between requests.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            update_matcher(bus_req);
            accepted_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
               bus_req = pending_requests.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {1'b0, bus_req.name_byte, bus_req.entry_char,
                              bus_req.entry_type, bus_req.entry_index};
               req_tuser  <= bus_req.cmd;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Monitor: compare every response with the oldest queued verdict.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      verdict_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_verdicts.size() == 0) begin
               note_failure($sformatf("unexpected response %b at %0t",
                                      rsp_tdata[2:0], $realtime));
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_tdata[0] !== want.matched || rsp_tdata[1] !== want.children ||
                   rsp_tdata[2] !== want.parent) begin
                  note_failure($sformatf(
                     "verdict mismatch at %0t: expected m=%b c=%b p=%b, got m=%b c=%b p=%b",
                     $realtime, want.matched, want.children, want.parent,
                     rsp_tdata[0], rsp_tdata[1], rsp_tdata[2]));
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_gap_pct);
      end
   end

   // Watchdog: end the run when no handshake happens for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------
   task automatic push_request(logic [1:0] cmd, logic [4:0] idx, logic [1:0] etype,
                               logic [7:0] chr, logic [7:0] nb);
      request_type r;
      r.cmd         = cmd;
      r.entry_index = idx;
      r.entry_type  = etype;
      r.entry_char  = chr;
      r.name_byte   = nb;
      pending_requests.push_back(r);
      pushed_count++;
   endtask

   task automatic push_entry(int idx, logic [1:0] etype, logic [7:0] chr);
      push_request(CMD_WRITE, idx[4:0], etype, chr, 8'($urandom));
      stim_kind[idx] = etype;
      stim_chr[idx]  = chr;
   endtask

   task automatic push_byte(logic [7:0] b);
      push_request(CMD_BYTE, 5'($urandom), 2'($urandom), 8'($urandom), b);
   endtask

   task automatic push_end();
      push_request(CMD_END, 5'($urandom), 2'($urandom), 8'($urandom), 8'($urandom));
   endtask

   // wait until every request is taken and every verdict is back, then let
   // the pipeline drain the last byte or write
   task automatic settle();
      do @(posedge clock);
      while (accepted_count != pushed_count || expected_verdicts.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [7:0] val);
      settle();
      csr_index <= idx;
      csr_wdata <= val;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_SEPARATOR: cfg_sep  = val;
         CSR_FOLD_EN:   cfg_fold = val[0];
         CSR_LENGTH:    cfg_len  = val[5:0];
         default: ;
      endcase
      restart_name();
   endtask

   function automatic logic [1:0] rand_kind();
      int r;
      r = $urandom_range(99);
      if (r < 55) return TYPE_LITERAL;
      if (r < 70) return TYPE_PERCENT;
      if (r < 85) return TYPE_STAR;
      return TYPE_ALT_LITERAL;
   endfunction

   // small alphabet so literals and name bytes collide often
   function automatic logic [7:0] pool_char();
      case ($urandom_range(5))
         0: return cfg_sep;
         1: return 8'h61;
         2: return 8'h62;
         3: return 8'h58;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] flip_case(logic [7:0] c);
      logic letter;
      letter = (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
      return (letter && $urandom_range(3) == 0) ? c ^ 8'h20 : c;
   endfunction

   // ---------------------------------------------------------------------------
   // Sequence: reset, directed checks, then random segments with fresh settings
   // ---------------------------------------------------------------------------
   initial begin
      int         seg;
      int         n;
      int         pick;
      int         cut;
      logic       inbox_head;
      logic [7:0] sep;
      logic [5:0] len;
      logic [7:0] c;
      logic [7:0] nm [$];

      for (int i = 0; i < MAX_STATES; i++) pat_tbl[i] = '0;
      restart_name();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // empty name against an empty pattern: the start position already accepts
      push_end();
      // unknown command: nothing happens
      push_request(CMD_UNUSED, 5'h1f, 2'd3, 8'hff, 8'hff);
      // INBOX / separator / percent / type-three literal 'z'
      for (int k = 0; k < 5; k++) push_entry(k, TYPE_LITERAL, inbox_letter(k));
      push_entry(5, TYPE_LITERAL, SEP_RESET);
      push_entry(6, TYPE_PERCENT, 8'h00);
      push_entry(7, TYPE_ALT_LITERAL, 8'h7a);
      write_csr(CSR_LENGTH, 8'd8);
      write_csr(CSR_FOLD_EN, 8'd1);
      // mixed-case INBOX, top byte through the percent: full match on the folded track
      nm = '{8'h69, 8'h6e, 8'h42, 8'h6f, 8'h58, SEP_RESET, 8'hff, 8'h7a};
      foreach (nm[i]) push_byte(nm[i]);
      push_end();
      // full match then a deeper level and a zero byte: parent only
      nm = '{8'h49, 8'h4e, 8'h42, 8'h4f, 8'h58, SEP_RESET, 8'h7a, SEP_RESET, 8'h00};
      foreach (nm[i]) push_byte(nm[i]);
      push_end();

      // define every table entry so any length is safe to select
      for (int i = 0; i < MAX_STATES; i++) push_entry(i, rand_kind(), 8'($urandom));

      seg = 0;
      while (pushed_count < TARGET_REQUESTS) begin
         if (pushed_count < TARGET_REQUESTS / 3) begin
            send_gap_pct = 34;
            recv_gap_pct = 51;
         end else if (pushed_count < 2 * TARGET_REQUESTS / 3) begin
            send_gap_pct = 51;
            recv_gap_pct = 34;
         end else begin
            send_gap_pct = 0;
            recv_gap_pct = 0;
         end

         case (seg % 5)
            0: sep = SEP_RESET;
            1: sep = 8'h00;
            2: sep = 8'hff;
            3: sep = 8'h2e;
            default: sep = 8'($urandom);
         endcase
         case (seg % 7)
            0: len = 6'd0;
            1: len = 6'(MAX_STATES);
            2: len = 6'h3f;                       // saturates to the table size
            3: len = 6'($urandom_range(62, 33));
            default: len = 6'($urandom_range(12, 1));
         endcase
         write_csr(CSR_SEPARATOR, sep);
         write_csr(CSR_FOLD_EN, {7'd0, seg % 3 != 0});
         write_csr(CSR_LENGTH, {2'b00, len});

         // new pattern; often it opens with INBOX and the separator
         n = live_len();
         inbox_head = n >= 6 && $urandom_range(99) < 40;
         for (int i = 0; i < n; i++) begin
            if (inbox_head && i < 5) push_entry(i, TYPE_LITERAL, inbox_letter(i));
            else if (inbox_head && i == 5) push_entry(i, TYPE_LITERAL, cfg_sep);
            else push_entry(i, rand_kind(), pool_char());
         end

         repeat ($urandom_range(9, 4)) begin
            nm = {};
            pick = $urandom_range(99);
            if (pick < 10) begin
               // leading INBOX in random case, with or without the separator
               for (int k = 0; k < 5; k++) nm.push_back(flip_case(inbox_letter(k)));
               if ($urandom_range(1) != 0) nm.push_back(cfg_sep);
               repeat ($urandom_range(3)) nm.push_back(pool_char());
            end else begin
               // walk the pattern so the name mostly fits it
               for (int i = 0; i < n; i++) begin
                  case (stim_kind[i])
                     TYPE_PERCENT: begin
                        repeat ($urandom_range(2)) begin
                           c = pool_char();
                           if (c == cfg_sep) c = c ^ 8'h01;
                           nm.push_back(c);
                        end
                     end
                     TYPE_STAR: begin
                        repeat ($urandom_range(3)) nm.push_back(pool_char());
                     end
                     default: nm.push_back(flip_case(stim_chr[i]));
                  endcase
               end
               // break about a third of them
               if (pick >= 65) begin
                  case ($urandom_range(3))
                     0: if (nm.size() != 0) void'(nm.pop_back());
                     1: begin
                        nm.push_back(cfg_sep);
                        nm.push_back(pool_char());
                     end
                     2: if (nm.size() != 0) nm[$urandom_range(nm.size() - 1)] = 8'($urandom);
                     default: nm.push_back(pool_char());
                  endcase
               end
            end
            // now and then a table write lands in the middle of a name
            cut = (nm.size() != 0 && $urandom_range(19) == 0) ?
                  $urandom_range(nm.size() - 1) : -1;
            for (int i = 0; i < nm.size(); i++) begin
               if (i == cut) push_entry($urandom_range(MAX_STATES - 1), rand_kind(), pool_char());
               push_byte(nm[i]);
            end
            if ($urandom_range(19) == 0) begin
               push_request(CMD_UNUSED, 5'($urandom), 2'($urandom), 8'($urandom), 8'($urandom));
            end
            // leave some names open: the next name runs on, or a later write abandons them
            if ($urandom_range(11) != 0) push_end();
         end
         seg++;
      end

      settle();
      if (failures == 0 && expected_verdicts.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// File: files.f
hdl/wnm_pkg.sv
hdl/wildcard_name_nfa_matcher.sv
bench/wildcard_name_nfa_matcher_tb.sv
